// ===== hdl/blpra_pkg.sv =====
// shared constants, types and register codes of the bilinear patch residual accumulator
`default_nettype none

package blpra_pkg;

   // weight format
   localparam int WEIGHT_BITS   = 14;
   localparam int WEIGHT_WIDTH  = WEIGHT_BITS + 1;
   localparam int PIX_WIDTH     = 8;
   localparam int PIX_SCALE     = 5;
   localparam int DESCALE_BITS  = WEIGHT_BITS - PIX_SCALE;

   // bottom-right weight is one minus three weights, each up to 2^WEIGHT_WIDTH-1
   localparam int WBR_WIDTH     = WEIGHT_WIDTH + 3;
   localparam int MIX_WIDTH     = WBR_WIDTH + PIX_WIDTH + 1;

   // template, gradients and difference
   localparam int VAL_WIDTH     = 16;
   localparam int DIFF_WIDTH    = MIX_WIDTH - DESCALE_BITS;
   localparam int SQ_WIDTH      = 2 * DIFF_WIDTH;
   localparam int RES_WIDTH     = DIFF_WIDTH + VAL_WIDTH;

   // running sums
   localparam int ACC_WIDTH     = 48;

   // decoupling queue
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_WIDTH    = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH    = $clog2(QUEUE_DEPTH + 1);

   // register port
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_IDX_WIDTH  = 2;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_WEIGHT_TL = 2'd0,
      CSR_WEIGHT_TR = 2'd1,
      CSR_WEIGHT_BL = 2'd2
   } csr_index_type;

   localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_ONE = WEIGHT_WIDTH'(1) << WEIGHT_BITS;

   typedef struct packed {
      logic [WEIGHT_WIDTH-1:0] top_left;
      logic [WEIGHT_WIDTH-1:0] top_right;
      logic [WEIGHT_WIDTH-1:0] bottom_left;
   } weights_type;

   // one classified sample waiting for the back end
   typedef struct packed {
      logic signed [DIFF_WIDTH-1:0] diff;
      logic signed [VAL_WIDTH-1:0]  grad_x;
      logic signed [VAL_WIDTH-1:0]  grad_y;
      logic                         last_pixel;
   } item_type;

endpackage

`default_nettype wire

// ===== hdl/blpra_ifs.sv =====
// request and response channel interfaces
`default_nettype none

interface blpra_req_if;
   import blpra_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [PIX_WIDTH-1:0]        pix_tl;
   logic [PIX_WIDTH-1:0]        pix_tr;
   logic [PIX_WIDTH-1:0]        pix_bl;
   logic [PIX_WIDTH-1:0]        pix_br;
   logic signed [VAL_WIDTH-1:0] template_value;
   logic signed [VAL_WIDTH-1:0] grad_x;
   logic signed [VAL_WIDTH-1:0] grad_y;
   logic                        last_pixel;

   modport source (
      output valid, pix_tl, pix_tr, pix_bl, pix_br, template_value, grad_x, grad_y,
             last_pixel,
      input  ready
   );
   modport sink (
      input  valid, pix_tl, pix_tr, pix_bl, pix_br, template_value, grad_x, grad_y,
             last_pixel,
      output ready
   );
endinterface

interface blpra_rsp_if;
   import blpra_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [ACC_WIDTH-1:0]        ssd_sum;
   logic signed [ACC_WIDTH-1:0] resid_x;
   logic signed [ACC_WIDTH-1:0] resid_y;

   modport source (
      output valid, ssd_sum, resid_x, resid_y,
      input  ready
   );
   modport sink (
      input  valid, ssd_sum, resid_x, resid_y,
      output ready
   );
endinterface

`default_nettype wire

// ===== hdl/blpra_csr.sv =====
// weight registers behind the apb-style register port
`default_nettype none

module blpra_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [blpra_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [blpra_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic      [blpra_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                      csr_pready,
   output blpra_pkg::weights_type                    weights
);
   import blpra_pkg::*;

   weights_type   weights_ff;
   weights_type   weights_in;
   csr_index_type index;
   logic          write_en;

   assign index      = csr_index_type'(csr_paddr[CSR_ADDR_WIDTH-1:CSR_ADDR_WIDTH-CSR_IDX_WIDTH]);
   assign write_en   = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign weights    = weights_ff;

   always_comb begin
      weights_in = weights_ff;
      csr_prdata = '0;
      case (index)
         CSR_WEIGHT_TL: begin
            csr_prdata = CSR_DATA_WIDTH'(weights_ff.top_left);
            if (write_en) weights_in.top_left = csr_pwdata[WEIGHT_WIDTH-1:0];
         end
         CSR_WEIGHT_TR: begin
            csr_prdata = CSR_DATA_WIDTH'(weights_ff.top_right);
            if (write_en) weights_in.top_right = csr_pwdata[WEIGHT_WIDTH-1:0];
         end
         CSR_WEIGHT_BL: begin
            csr_prdata = CSR_DATA_WIDTH'(weights_ff.bottom_left);
            if (write_en) weights_in.bottom_left = csr_pwdata[WEIGHT_WIDTH-1:0];
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weights_ff.top_left    <= WEIGHT_ONE;
         weights_ff.top_right   <= '0;
         weights_ff.bottom_left <= '0;
      end else begin
         weights_ff <= weights_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/blpra_front.sv =====
// front end: bilinear mix, rounding descale and template difference
`default_nettype none

module blpra_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire blpra_pkg::weights_type weights,
   blpra_req_if.sink                   req_chan,
   output logic                        push_valid,
   input  wire logic                   push_ready,
   output blpra_pkg::item_type         push_item
);
   import blpra_pkg::*;

   localparam logic signed [MIX_WIDTH-1:0] ROUND = MIX_WIDTH'(1) << (DESCALE_BITS - 1);
   localparam logic signed [WBR_WIDTH-1:0] ONE_S = WBR_WIDTH'(1) << WEIGHT_BITS;

   logic signed [WBR_WIDTH-1:0]   w_tl, w_tr, w_bl, w_br;
   logic signed [PIX_WIDTH:0]     px_tl, px_tr, px_bl, px_br;

   // product stage
   logic                          valid_ff, valid_in;
   logic signed [MIX_WIDTH-1:0]   p_tl_ff, p_tr_ff, p_bl_ff, p_br_ff;
   logic signed [MIX_WIDTH-1:0]   p_tl_in, p_tr_in, p_bl_in, p_br_in;
   logic signed [VAL_WIDTH-1:0]   tmpl_ff, gx_ff, gy_ff;
   logic                          last_ff;

   logic signed [MIX_WIDTH-1:0]   mix;
   logic signed [MIX_WIDTH-1:0]   interp;
   logic                          advance;

   assign w_tl = signed'(WBR_WIDTH'(weights.top_left));
   assign w_tr = signed'(WBR_WIDTH'(weights.top_right));
   assign w_bl = signed'(WBR_WIDTH'(weights.bottom_left));
   assign w_br = ONE_S - w_tl - w_tr - w_bl;

   assign px_tl = signed'({1'b0, req_chan.pix_tl});
   assign px_tr = signed'({1'b0, req_chan.pix_tr});
   assign px_bl = signed'({1'b0, req_chan.pix_bl});
   assign px_br = signed'({1'b0, req_chan.pix_br});

   assign req_chan.ready = ~valid_ff | push_ready;
   assign advance        = req_chan.valid & req_chan.ready;

   always_comb begin
      p_tl_in  = px_tl * w_tl;
      p_tr_in  = px_tr * w_tr;
      p_bl_in  = px_bl * w_bl;
      p_br_in  = px_br * w_br;
      valid_in = valid_ff;
      if (req_chan.ready) valid_in = req_chan.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p_tl_ff <= p_tl_in;
         p_tr_ff <= p_tr_in;
         p_bl_ff <= p_bl_in;
         p_br_ff <= p_br_in;
         tmpl_ff <= req_chan.template_value;
         gx_ff   <= req_chan.grad_x;
         gy_ff   <= req_chan.grad_y;
         last_ff <= req_chan.last_pixel;
      end
   end

   // sum, round half up, floor shift, subtract template
   always_comb begin
      mix                  = p_tl_ff + p_tr_ff + p_bl_ff + p_br_ff + ROUND;
      interp               = mix >>> DESCALE_BITS;
      push_item.diff       = DIFF_WIDTH'(interp) - DIFF_WIDTH'(tmpl_ff);
      push_item.grad_x     = gx_ff;
      push_item.grad_y     = gy_ff;
      push_item.last_pixel = last_ff;
   end

   assign push_valid = valid_ff;

endmodule

`default_nettype wire

// ===== hdl/blpra_queue.sv =====
// short fifo between front and back ends
`default_nettype none

module blpra_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   output logic                     push_ready,
   input  wire blpra_pkg::item_type push_item,
   output logic                     pop_valid,
   input  wire logic                pop_ready,
   output blpra_pkg::item_type      pop_item
);
   import blpra_pkg::*;

   item_type               entries_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0]  count_ff, count_in;
   logic                   do_push, do_pop;

   assign push_ready = count_ff != QCNT_WIDTH'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;
   assign pop_item   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = wr_ptr_ff + 1'b1;
      if (do_pop) rd_ptr_in = rd_ptr_ff + 1'b1;
      if (do_push & ~do_pop) count_in = count_ff + 1'b1;
      else if (~do_push & do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entries_ff[wr_ptr_ff] <= push_item;
   end

endmodule

`default_nettype wire

// ===== hdl/blpra_back.sv =====
// back end: products, saturating sums and the result register
`default_nettype none

module blpra_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                pop_valid,
   output logic                     pop_ready,
   input  wire blpra_pkg::item_type pop_item,
   blpra_rsp_if.source              rsp_chan
);
   import blpra_pkg::*;

   localparam int SUM_WIDTH = ACC_WIDTH + 1;

   // product stage
   logic                        p_valid_ff, p_valid_in;
   logic signed [SQ_WIDTH-1:0]  sq_ff, sq_in;
   logic signed [RES_WIDTH-1:0] rx_ff, rx_in, ry_ff, ry_in;
   logic                        p_last_ff;

   // accumulators
   logic [ACC_WIDTH-1:0]        ssd_ff, ssd_in;
   logic signed [ACC_WIDTH-1:0] accx_ff, accx_in, accy_ff, accy_in;
   logic [SUM_WIDTH-1:0]        ssd_sum;
   logic signed [SUM_WIDTH-1:0] x_sum, y_sum;
   logic [ACC_WIDTH-1:0]        ssd_sat;
   logic signed [ACC_WIDTH-1:0] x_sat, y_sat;

   // result register
   logic                        out_valid_ff, out_valid_in;
   logic [ACC_WIDTH-1:0]        out_ssd_ff;
   logic signed [ACC_WIDTH-1:0] out_x_ff, out_y_ff;

   logic                        acc_adv;
   logic                        emit;

   assign acc_adv   = p_valid_ff & (~p_last_ff | ~out_valid_ff | rsp_chan.ready);
   assign emit      = acc_adv & p_last_ff;
   assign pop_ready = ~p_valid_ff | acc_adv;

   always_comb begin
      sq_in      = pop_item.diff * pop_item.diff;
      rx_in      = pop_item.diff * pop_item.grad_x;
      ry_in      = pop_item.diff * pop_item.grad_y;
      p_valid_in = p_valid_ff;
      if (pop_ready) p_valid_in = pop_valid;
   end

   always_ff @(posedge clock) begin
      if (pop_valid & pop_ready) begin
         sq_ff     <= sq_in;
         rx_ff     <= rx_in;
         ry_ff     <= ry_in;
         p_last_ff <= pop_item.last_pixel;
      end
   end

   // saturating adds: square is never negative, residual sums clamp both ways
   always_comb begin
      ssd_sum = SUM_WIDTH'(ssd_ff) + SUM_WIDTH'(unsigned'(sq_ff));
      x_sum   = SUM_WIDTH'(accx_ff) + SUM_WIDTH'(rx_ff);
      y_sum   = SUM_WIDTH'(accy_ff) + SUM_WIDTH'(ry_ff);

      ssd_sat = ssd_sum[ACC_WIDTH] ? '1 : ssd_sum[ACC_WIDTH-1:0];

      if (x_sum[ACC_WIDTH] != x_sum[ACC_WIDTH-1])
         x_sat = x_sum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                  : {1'b0, {(ACC_WIDTH-1){1'b1}}};
      else
         x_sat = x_sum[ACC_WIDTH-1:0];

      if (y_sum[ACC_WIDTH] != y_sum[ACC_WIDTH-1])
         y_sat = y_sum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                  : {1'b0, {(ACC_WIDTH-1){1'b1}}};
      else
         y_sat = y_sum[ACC_WIDTH-1:0];

      ssd_in  = ssd_ff;
      accx_in = accx_ff;
      accy_in = accy_ff;
      if (emit) begin
         ssd_in  = '0;
         accx_in = '0;
         accy_in = '0;
      end else if (acc_adv) begin
         ssd_in  = ssd_sat;
         accx_in = x_sat;
         accy_in = y_sat;
      end

      out_valid_in = out_valid_ff;
      if (emit) out_valid_in = 1'b1;
      else if (rsp_chan.ready) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         ssd_ff       <= '0;
         accx_ff      <= '0;
         accy_ff      <= '0;
      end else begin
         p_valid_ff   <= p_valid_in;
         out_valid_ff <= out_valid_in;
         ssd_ff       <= ssd_in;
         accx_ff      <= accx_in;
         accy_ff      <= accy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_ssd_ff <= ssd_sat;
         out_x_ff   <= x_sat;
         out_y_ff   <= y_sat;
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.ssd_sum = out_ssd_ff;
   assign rsp_chan.resid_x = out_x_ff;
   assign rsp_chan.resid_y = out_y_ff;

endmodule

`default_nettype wire

// ===== hdl/bilinear_patch_residual_accumulator_top.sv =====
// top level of the bilinear patch residual accumulator
`default_nettype none

//  port group   direction  moves
//  req_chan     in         one sample: four pixels, template, gradients, last flag
//  rsp_chan     out        window sums: ssd, x residual, y residual
//  csr_*        in/out     apb-style access to the three weight registers
//
//  one sample per cycle sustained while the queue is not full; the accumulator
//  add feeds back on itself through the sum registers
//  a window result is presented once its last sample has passed the front
//  product register, a queue entry, the back product register and the result
//  register
//  synchronous reset clears valids, queue pointers and sums; weights return
//  to top-left only
//  a stalled result register holds back only a last sample, plain samples
//  keep accumulating; the four-entry queue absorbs back-end stalls

module bilinear_patch_residual_accumulator_top (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   blpra_req_if.sink                                 req_chan,
   blpra_rsp_if.source                               rsp_chan,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [blpra_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [blpra_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic      [blpra_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                      csr_pready
);
   import blpra_pkg::*;

   weights_type weights;

   // front to queue
   logic     push_valid;
   logic     push_ready;
   item_type push_item;

   // queue to back
   logic     pop_valid;
   logic     pop_ready;
   item_type pop_item;

   // weight registers
   blpra_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .weights     (weights)
   );

   // interpolation and difference per request
   blpra_front u_front (
      .clock      (clock),
      .reset      (reset),
      .weights    (weights),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   // decouples front stalls from back stalls
   blpra_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // products, saturating sums, result register
   blpra_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// self-checking testbench for the bilinear patch residual accumulator
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import blpra_pkg::*;

   // ---------------------------------------------------------------------
   // run shape
   // ---------------------------------------------------------------------
   localparam int CLOCK_HALF      = 6;       // 12 ns period
   localparam int RESET_CYCLES    = 10;
   localparam int SETTLE_CYCLES   = 16;      // margin for a result to pass the pipeline registers after the last sample
   localparam int WATCHDOG_LIMIT  = 5000;    // well above the longest response hold-off
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int RANDOM_PHASES   = 8;
   localparam int PHASE_SAMPLES   = 140;
   localparam int PLAN_ROWS       = 19;
   localparam int SAT_SAMPLES     = 48;      // max-difference samples in one long window
   localparam int SAT_RECOVER     = 24;      // opposite-gradient samples that pull residuals back
   localparam int REPORT_LIMIT    = 10;
   localparam int CSR_STRIDE      = 4;

   localparam longint SSD_MAX    = (longint'(1) <<< ACC_WIDTH) - 1;
   localparam longint RES_MAX    = (longint'(1) <<< (ACC_WIDTH - 1)) - 1;
   localparam longint RES_MIN    = -(longint'(1) <<< (ACC_WIDTH - 1));
   localparam longint ROUND_HALF = longint'(1) <<< (DESCALE_BITS - 1);

   localparam logic [WEIGHT_WIDTH-1:0] W1 = WEIGHT_ONE;        // weight of exactly one
   localparam logic [WEIGHT_WIDTH-1:0] WH = WEIGHT_ONE >> 1;   // one half
   localparam logic [WEIGHT_WIDTH-1:0] WQ = WEIGHT_ONE >> 2;   // one quarter

   // ---------------------------------------------------------------------
   // types
   // ---------------------------------------------------------------------
   typedef struct packed {
      logic [PIX_WIDTH-1:0]        pix_tl;
      logic [PIX_WIDTH-1:0]        pix_tr;
      logic [PIX_WIDTH-1:0]        pix_bl;
      logic [PIX_WIDTH-1:0]        pix_br;
      logic signed [VAL_WIDTH-1:0] template_value;
      logic signed [VAL_WIDTH-1:0] grad_x;
      logic signed [VAL_WIDTH-1:0] grad_y;
      logic                        last_pixel;
   } sample_type;

   typedef struct packed {
      logic [ACC_WIDTH-1:0]        ssd;
      logic signed [ACC_WIDTH-1:0] resid_x;
      logic signed [ACC_WIDTH-1:0] resid_y;
   } window_sums_type;

   // hand-computed sums that replace the predicted ones for a given sample
   typedef struct packed {
      bit              typed;
      window_sums_type want;
   } typed_sums_type;

   // one row of the directed plan: optional weight change, then one sample
   typedef struct packed {
      bit                      set_weights;
      logic [WEIGHT_WIDTH-1:0] w_tl;
      logic [WEIGHT_WIDTH-1:0] w_tr;
      logic [WEIGHT_WIDTH-1:0] w_bl;
      sample_type              stim;
      bit                      typed;
      window_sums_type         want;
   } plan_row_type;

   typedef enum {RSP_ALWAYS, RSP_RANDOM, RSP_PERIODIC} rsp_pace_type;

   // ---------------------------------------------------------------------
   // clock, reset, ports
   // ---------------------------------------------------------------------
   logic                      clock;
   logic                      reset;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   blpra_req_if req_chan ();
   blpra_rsp_if rsp_chan ();

   bilinear_patch_residual_accumulator_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // predictor state: weight mirror and the three running sums
   // ---------------------------------------------------------------------
   logic [WEIGHT_WIDTH-1:0] weight_tl = W1;
   logic [WEIGHT_WIDTH-1:0] weight_tr = '0;
   logic [WEIGHT_WIDTH-1:0] weight_bl = '0;
   longint                  acc_ssd   = 0;
   longint                  acc_rx    = 0;
   longint                  acc_ry    = 0;

   window_sums_type pending_window_sums [$];   // sums the block still owes, oldest first
   typed_sums_type  typed_window_sums [$];     // one entry per offered sample, in order

   // pacing controls shared by the sender, the receiver and the stimulus
   bit           bursts_on        = 1'b0;
   int           burst_left       = 0;
   rsp_pace_type rsp_pace         = RSP_ALWAYS;
   int           pace_period      = 4;
   int           pace_duty        = 2;
   bit           hold_off_pending = 1'b0;

   // bookkeeping
   int mismatches        = 0;
   int samples_taken     = 0;
   int windows_checked   = 0;
   int saturated_windows = 0;
   int input_stalls      = 0;
   int hold_offs_done    = 0;
   int weight_settings   = 1;
   int quiet_cycles      = 0;

   function automatic void note_failure(input string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("mismatch: %s", msg);
   endfunction

   function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // bilinear mix, round-half-up descale, difference against the template,
   // then saturating adds into the three window sums; a last sample hands
   // the sums out and starts a fresh window
   function automatic bit accumulate_window(input sample_type s, output window_sums_type sums);
      longint w_tl, w_tr, w_bl, w_br;
      longint mix, interp, diff, gx, gy, tv;
      w_tl   = weight_tl;
      w_tr   = weight_tr;
      w_bl   = weight_bl;
      // bottom-right takes what is left of one, and may go negative
      w_br   = longint'(WEIGHT_ONE) - w_tl - w_tr - w_bl;
      mix    = longint'(s.pix_tl) * w_tl + longint'(s.pix_tr) * w_tr
             + longint'(s.pix_bl) * w_bl + longint'(s.pix_br) * w_br;
      interp = (mix + ROUND_HALF) >>> DESCALE_BITS;   // floor shift
      tv     = s.template_value;
      gx     = s.grad_x;
      gy     = s.grad_y;
      diff   = interp - tv;
      acc_ssd = clamp_to(acc_ssd + diff * diff, 0, SSD_MAX);
      acc_rx  = clamp_to(acc_rx + diff * gx, RES_MIN, RES_MAX);
      acc_ry  = clamp_to(acc_ry + diff * gy, RES_MIN, RES_MAX);
      sums = '0;
      if (!s.last_pixel)
         return 1'b0;
      sums.ssd     = acc_ssd[ACC_WIDTH-1:0];
      sums.resid_x = acc_rx[ACC_WIDTH-1:0];
      sums.resid_y = acc_ry[ACC_WIDTH-1:0];
      acc_ssd = 0;
      acc_rx  = 0;
      acc_ry  = 0;
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // random content
   // ---------------------------------------------------------------------
   function automatic logic [PIX_WIDTH-1:0] random_pixel();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return PIX_WIDTH'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [VAL_WIDTH-1:0] random_word();
      case ($urandom_range(0, 7))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         2:       return VAL_WIDTH'($urandom_range(0, 63)) - 16'd32;   // small, either sign
         default: return VAL_WIDTH'($urandom);
      endcase
   endfunction

   function automatic sample_type random_sample(input bit last);
      sample_type s;
      s.pix_tl         = random_pixel();
      s.pix_tr         = random_pixel();
      s.pix_bl         = random_pixel();
      s.pix_br         = random_pixel();
      s.template_value = random_word();
      s.grad_x         = random_word();
      s.grad_y         = random_word();
      s.last_pixel     = last;
      return s;
   endfunction

   function automatic logic [WEIGHT_WIDTH-1:0] random_weight();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return W1;
         default: return WEIGHT_WIDTH'($urandom_range(0, 16384));
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // request side: drive at the falling edge, wait for the handshake
   // ---------------------------------------------------------------------
   task automatic send_sample(input sample_type s, input bit typed,
                              input window_sums_type want);
      int gap;
      typed_window_sums.push_back('{typed, want});
      @(negedge clock);
      req_chan.valid          <= 1'b1;
      req_chan.pix_tl         <= s.pix_tl;
      req_chan.pix_tr         <= s.pix_tr;
      req_chan.pix_bl         <= s.pix_bl;
      req_chan.pix_br         <= s.pix_br;
      req_chan.template_value <= s.template_value;
      req_chan.grad_x         <= s.grad_x;
      req_chan.grad_y         <= s.grad_y;
      req_chan.last_pixel     <= s.last_pixel;
      do @(posedge clock); while (!req_chan.ready);
      // bursts of random length, random gaps between them
      if (bursts_on) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(0, 12);
            gap        = $urandom_range(1, 6);
            @(negedge clock);
            req_chan.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   // drop valid, let every owed window arrive, then give the pipe time to empty
   task automatic settle_block();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_window_sums.size() != 0 || typed_window_sums.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // apb write in setup and access cycles, then a read back of the same register
   task automatic write_weight(input csr_index_type idx, input logic [WEIGHT_WIDTH-1:0] value);
      logic [CSR_DATA_WIDTH-1:0] readback;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_WIDTH'(CSR_STRIDE * int'(idx));
      csr_pwdata  <= CSR_DATA_WIDTH'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         CSR_WEIGHT_TL: weight_tl = value;
         CSR_WEIGHT_TR: weight_tr = value;
         default:       weight_bl = value;
      endcase
      if (readback[WEIGHT_WIDTH-1:0] !== value)
         note_failure($sformatf("weight register %s reads %0d, wrote %0d",
                                idx.name(), readback[WEIGHT_WIDTH-1:0], value));
   endtask

   task automatic apply_weights(input logic [WEIGHT_WIDTH-1:0] tl,
                                input logic [WEIGHT_WIDTH-1:0] tr,
                                input logic [WEIGHT_WIDTH-1:0] bl);
      settle_block();
      write_weight(CSR_WEIGHT_TL, tl);
      write_weight(CSR_WEIGHT_TR, tr);
      write_weight(CSR_WEIGHT_BL, bl);
      weight_settings++;
   endtask

   // ---------------------------------------------------------------------
   // response side: ready on a pattern of its own, plus one long hold-off
   // ---------------------------------------------------------------------
   initial begin : response_pacer
      int tick;
      tick = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         tick++;
         if (hold_off_pending) begin
            // hold ready low while the sender keeps offering, so the queue fills
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
            hold_off_pending = 1'b0;
            hold_offs_done++;
         end else begin
            case (rsp_pace)
               RSP_ALWAYS: rsp_chan.ready <= 1'b1;
               RSP_RANDOM: rsp_chan.ready <= ($urandom_range(0, 4) < 3);
               default:    rsp_chan.ready <= ((tick % pace_period) < pace_duty);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor: predict on every accepted request, check every accepted response
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : channel_monitor
      sample_type      taken;
      window_sums_type sums;
      window_sums_type want;
      typed_sums_type  pin;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            taken = '{req_chan.pix_tl, req_chan.pix_tr, req_chan.pix_bl, req_chan.pix_br,
                      req_chan.template_value, req_chan.grad_x, req_chan.grad_y,
                      req_chan.last_pixel};
            pin = typed_window_sums.pop_front();
            samples_taken++;
            if (accumulate_window(taken, sums))
               pending_window_sums.push_back(pin.typed ? pin.want : sums);
         end else if (req_chan.valid) begin
            input_stalls++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            windows_checked++;
            if (rsp_chan.ssd_sum == '1)
               saturated_windows++;
            if (pending_window_sums.size() == 0) begin
               note_failure($sformatf(
                  "window %0d: expected none, got ssd %0d x %0d y %0d",
                  windows_checked, rsp_chan.ssd_sum, rsp_chan.resid_x, rsp_chan.resid_y));
            end else begin
               want = pending_window_sums.pop_front();
               if (rsp_chan.ssd_sum !== want.ssd || rsp_chan.resid_x !== want.resid_x ||
                   rsp_chan.resid_y !== want.resid_y)
                  note_failure($sformatf(
                     "window %0d: expected ssd %0d x %0d y %0d, got ssd %0d x %0d y %0d",
                     windows_checked, want.ssd, want.resid_x, want.resid_y,
                     rsp_chan.ssd_sum, rsp_chan.resid_x, rsp_chan.resid_y));
            end
         end
      end
   end

   // watchdog: too long without any handshake on either channel ends the run
   always @(posedge clock) begin : watchdog
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no request or window result for %0d cycles", quiet_cycles);
         $display("testbench failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      plan_row_type            plan [PLAN_ROWS];
      sample_type              s;
      int                      fill;
      int                      window_len;
      bit                      close;
      bit                      single;
      logic [WEIGHT_WIDTH-1:0] a, b, c;

      // every input known from time zero
      reset                   = 1'b1;
      csr_psel                = 1'b0;
      csr_penable             = 1'b0;
      csr_pwrite              = 1'b0;
      csr_paddr               = '0;
      csr_pwdata              = '0;
      req_chan.valid          = 1'b0;
      req_chan.pix_tl         = '0;
      req_chan.pix_tr         = '0;
      req_chan.pix_bl         = '0;
      req_chan.pix_br         = '0;
      req_chan.template_value = '0;
      req_chan.grad_x         = '0;
      req_chan.grad_y         = '0;
      req_chan.last_pixel     = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed plan; with the reset weights the interpolated value is just 32 * top-left,
      // so those rows carry their sums typed in
      plan = '{
         //   set  tl  tr  bl     tl   tr   bl   br  template  gx      gy    last
         '{1'b0, 0, 0, 0, '{  0,   0,   0,   0,      0,      0,      0, 1'b1},
           1'b1, '{0, 0, 0}},
         '{1'b0, 0, 0, 0, '{255, 255, 255, 255,      0,      1,     -1, 1'b1},
           1'b1, '{66585600, 8160, -8160}},
         '{1'b0, 0, 0, 0, '{  0, 255, 255, 255, -32768,  32767, -32768, 1'b1},
           1'b1, '{1073741824, 1073709056, -1073741824}},
         '{1'b0, 0, 0, 0, '{255,   0,   0,   0,  32767, -32768,  32767, 1'b1},
           1'b1, '{605504449, 806322176, -806297569}},
         // a three-sample window
         '{1'b0, 0, 0, 0, '{ 12, 200,   7,  99,  -1000,   1234,  -4321, 1'b0},
           1'b0, '{0, 0, 0}},
         '{1'b0, 0, 0, 0, '{255,   0, 128,   1,   5000, -32768,  32767, 1'b0},
           1'b0, '{0, 0, 0}},
         '{1'b0, 0, 0, 0, '{ 77,  77,  77,  77,   2464,    100,    100, 1'b1},
           1'b0, '{0, 0, 0}},
         // each single corner at full weight
         '{1'b1, 0, W1, 0, '{  0, 200,   0,   0,    100,      2,     -3, 1'b1},
           1'b1, '{39690000, 12600, -18900}},
         '{1'b1, 0, 0, W1, '{  0,   0,  17,   0,     -5,     -1,      0, 1'b1},
           1'b1, '{301401, -549, 0}},
         '{1'b1, 0, 0, 0,  '{  0,   0,   0, 255,   8160,  32767, -32768, 1'b1},
           1'b1, '{0, 0, 0}},
         // weights well above one: bottom-right goes negative
         '{1'b1, W1, W1, W1, '{255, 255, 255,  0,      0,  32767,  32767, 1'b1},
           1'b0, '{0, 0, 0}},
         '{1'b0, 0, 0, 0,  '{  0,   0,   0, 255,      0, -32768,      1, 1'b1},
           1'b0, '{0, 0, 0}},
         // half weights on top-left and top-right, one pixel lit
         '{1'b1, WH, WH, 0, '{  1,   0,   0,   0,      0,      1,      1, 1'b1},
           1'b0, '{0, 0, 0}},
         '{1'b0, 0, 0, 0,  '{  0,   1,   0,   0,     -1,      1,      1, 1'b1},
           1'b0, '{0, 0, 0}},
         // even split, four-sample window
         '{1'b1, WQ, WQ, WQ, '{ 10,  20,  30,  40,   -200,    300,   -400, 1'b0},
           1'b0, '{0, 0, 0}},
         '{1'b0, 0, 0, 0,  '{255,   0, 255,   0,  32767,  32767,  32767, 1'b0},
           1'b0, '{0, 0, 0}},
         '{1'b0, 0, 0, 0,  '{  0, 255,   0, 255, -32768, -32768, -32768, 1'b0},
           1'b0, '{0, 0, 0}},
         '{1'b0, 0, 0, 0,  '{128, 128, 128, 128,   4096,     -1,      1, 1'b1},
           1'b0, '{0, 0, 0}},
         '{1'b1, W1, W1, 0, '{255, 255,   0, 255,  -7777,  12345, -23456, 1'b1},
           1'b0, '{0, 0, 0}}
      };

      foreach (plan[i]) begin
         if (plan[i].set_weights)
            apply_weights(plan[i].w_tl, plan[i].w_tr, plan[i].w_bl);
         send_sample(plan[i].stim, plan[i].typed, plan[i].want);
      end

      // one long window at the largest difference these weights give,
      // then opposite gradients pull the residuals back toward zero
      apply_weights(W1, W1, W1);
      s = '{8'd255, 8'd255, 8'd255, 8'd0, -16'sd32768, 16'sd32767, -16'sd32768, 1'b0};
      repeat (SAT_SAMPLES) send_sample(s, 1'b0, '0);
      s.grad_x = -16'sd32768;
      s.grad_y = 16'sd32767;
      for (int k = 0; k < SAT_RECOVER; k++) begin
         s.last_pixel = (k == SAT_RECOVER - 1);
         send_sample(s, 1'b0, '0);
      end

      // random phases, each with its own weights and pacing
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase % 2 == 0) begin
            // a proper bilinear split that sums to at most one
            a = WEIGHT_WIDTH'($urandom_range(0, 16384));
            b = WEIGHT_WIDTH'($urandom_range(0, 16384 - a));
            c = WEIGHT_WIDTH'($urandom_range(0, 16384 - a - b));
         end else begin
            a = random_weight();
            b = random_weight();
            c = random_weight();
         end
         apply_weights(a, b, c);

         single      = 1'b0;
         burst_left  = 0;
         pace_period = $urandom_range(2, 9);
         pace_duty   = $urandom_range(1, pace_period - 1);
         if (phase == 0) begin
            // a stretch with no idling on either side
            bursts_on = 1'b0;
            rsp_pace  = RSP_ALWAYS;
         end else if (phase == 3) begin
            // one-sample windows while the receiver holds off for a long time
            bursts_on        = 1'b0;
            rsp_pace         = RSP_RANDOM;
            single           = 1'b1;
            hold_off_pending = 1'b1;
         end else begin
            bursts_on = ($urandom_range(0, 3) != 0);
            rsp_pace  = rsp_pace_type'($urandom_range(0, 2));
         end

         fill       = 0;
         window_len = single ? 1 : $urandom_range(1, 8);
         for (int n = 0; n < PHASE_SAMPLES; n++) begin
            fill++;
            close = (fill >= window_len) || (n == PHASE_SAMPLES - 1);
            send_sample(random_sample(close), 1'b0, '0);
            if (close) begin
               fill = 0;
               if (single)
                  window_len = 1;
               else if ($urandom_range(0, 7) == 0)
                  window_len = $urandom_range(20, 60);
               else
                  window_len = $urandom_range(1, 8);
            end
         end
      end

      // drain: every owed window, then the pipeline latency
      bursts_on = 1'b0;
      rsp_pace  = RSP_ALWAYS;
      settle_block();

      $display("covered %0d samples in %0d windows over %0d weight settings, %0d saturated",
               samples_taken, windows_checked, weight_settings, saturated_windows);
      $display("input held back for %0d cycles, with %0d long result hold-off(s)",
               input_stalls, hold_offs_done);
      if (mismatches == 0) begin
         $display("testbench passed");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("testbench failed");
      end
      $finish;
   end

endmodule
